// File: hdl/lfn_pkg.sv
// shared types and constants for the long-filename entry builder
package lfn_pkg;

	localparam int MAX_ENTRIES_DEF = 20;
	localparam int SLOTS           = 13;
	localparam int SLOT_W          = 16;
	localparam int SHORT_LEN       = 11;

	localparam logic [6:0]        ORD_LAST  = 7'h40;
	localparam logic [SLOT_W-1:0] SLOT_PAD  = 16'hFFFF;
	localparam logic [SLOT_W-1:0] SLOT_TERM = 16'h0000;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_SHORT = 2'd1,
		CMD_LONG  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EMIT = 2'b10
	} state_t;

	typedef logic [SLOT_W-1:0] slot_t;

endpackage

// File: hdl/lfn_entry_builder.sv
// long-filename directory entry builder: checksum, slot buffer and entry sequencer
//
// Builds the name part of FAT long-filename directory entries. A start beat
// (cmd 0) sets the entry count, saturated into 1..MAX_ENTRIES, and clears the
// checksum and counters. Short-name beats (cmd 1) fold the first eleven bytes
// into the rotate-right-and-add checksum; later ones are ignored. Long-name
// beats (cmd 2) fill a 13-slot buffer, one slot per beat; a zero byte ends
// the name. One result beat goes out per entry, ordinal from 1, with 0x40 set
// on the final entry, and last_of_run marks the last result of an input beat.
// Timing: start, short-name and ordinary long-name beats are taken back to back.
// A long-name beat that fills an entry first writes the slot; the sequencer then
// moves the entry into the output register. The terminator writes its slot and
// pads the rest; the sequencer then emits the current entry and the padding
// entries, since a single sequencer loads one entry per cycle into the output
// register while out_stall is low. in_stall stays high while the sequencer is
// emitting.
module lfn_entry_builder #(
	parameter int MAX_ENTRIES = lfn_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  ordinal,
	output logic [7:0]  checksum,
	output logic [63:0] chars_0_3,
	output logic [63:0] chars_4_7,
	output logic [63:0] chars_8_11,
	output logic [15:0] char_12,
	output logic        last_of_run
);
	import lfn_pkg::*;

	state_t     state_q;
	logic [7:0] short_sum_q;
	logic [3:0] short_count_q;
	logic [5:0] entry_total_q;
	logic [5:0] entry_index_q;
	logic [3:0] slot_idx_q;
	logic       name_ended_q;
	logic       term_q;
	slot_t      slot_q [SLOTS];

	logic       out_valid_q;
	logic [6:0] ordinal_q;
	logic [7:0] checksum_q;
	logic [63:0] chars_0_3_q, chars_4_7_q, chars_8_11_q;
	logic [15:0] char_12_q;
	logic       last_q;

	logic       in_acc;
	logic       out_free;
	logic       long_ok;
	logic       load_out;
	logic [6:0] idx_plus;
	logic       is_final;
	logic       last_d;
	logic [7:0] sum_rot;
	logic [7:0] total_sat;

	// input beat is taken only while the sequencer rests
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// output register frees when empty or when its beat leaves
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == S_EMIT) && out_free;

	// long-name byte counts only before the end and within the entry budget
	assign long_ok = !name_ended_q && (entry_index_q < entry_total_q);

	// ordinal of the entry being emitted and its final flag
	assign idx_plus = {1'b0, entry_index_q} + 7'd1;
	assign is_final = (idx_plus == {1'b0, entry_total_q});
	assign last_d   = !term_q || is_final;

	// checksum step: rotate right one bit, then add the byte
	assign sum_rot = {short_sum_q[0], short_sum_q[7:1]} + value;

	// entry count saturated into 1..MAX_ENTRIES
	always_comb begin
		total_sat = value;
		if (value == 8'd0) begin
			total_sat = 8'd1;
		end
		if (value > 8'(MAX_ENTRIES)) begin
			total_sat = 8'(MAX_ENTRIES);
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			short_sum_q   <= '0;
			short_count_q <= '0;
			entry_total_q <= '0;
			entry_index_q <= '0;
			slot_idx_q    <= '0;
			name_ended_q  <= 1'b0;
			term_q        <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (cmd)
							CMD_START: begin
								entry_total_q <= total_sat[5:0];
								short_sum_q   <= '0;
								short_count_q <= '0;
								entry_index_q <= '0;
								slot_idx_q    <= '0;
								name_ended_q  <= 1'b0;
							end
							CMD_SHORT: begin
								if (short_count_q < 4'(SHORT_LEN)) begin
									short_sum_q   <= sum_rot;
									short_count_q <= short_count_q + 4'd1;
								end
							end
							CMD_LONG: begin
								if (long_ok) begin
									if (value != 8'd0) begin
										if (slot_idx_q == 4'(SLOTS - 1)) begin
											slot_idx_q <= '0;
											term_q     <= 1'b0;
											state_q    <= S_EMIT;
										end else begin
											slot_idx_q <= slot_idx_q + 4'd1;
										end
									end else begin
										slot_idx_q   <= '0;
										name_ended_q <= 1'b1;
										term_q       <= 1'b1;
										state_q      <= S_EMIT;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						entry_index_q <= idx_plus[5:0];
						// padding continues until every entry has gone out
						if (!term_q || is_final) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// slot buffer: one slot per name byte, terminator pads the rest
	always_ff @(posedge clk) begin
		if (in_acc && (cmd == CMD_LONG) && long_ok) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (4'(s) == slot_idx_q) begin
					slot_q[s] <= (value != 8'd0) ? slot_t'(value) : SLOT_TERM;
				end else if ((value == 8'd0) && (4'(s) > slot_idx_q)) begin
					slot_q[s] <= SLOT_PAD;
				end
			end
		end else if (load_out && term_q) begin
			for (int s = 0; s < SLOTS; s++) begin
				slot_q[s] <= SLOT_PAD;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load_out;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			ordinal_q    <= idx_plus | (is_final ? ORD_LAST : 7'd0);
			checksum_q   <= short_sum_q;
			chars_0_3_q  <= {slot_q[3], slot_q[2], slot_q[1], slot_q[0]};
			chars_4_7_q  <= {slot_q[7], slot_q[6], slot_q[5], slot_q[4]};
			chars_8_11_q <= {slot_q[11], slot_q[10], slot_q[9], slot_q[8]};
			char_12_q    <= slot_q[12];
			last_q       <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign ordinal     = ordinal_q;
	assign checksum    = checksum_q;
	assign chars_0_3   = chars_0_3_q;
	assign chars_4_7   = chars_4_7_q;
	assign chars_8_11  = chars_8_11_q;
	assign char_12     = char_12_q;
	assign last_of_run = last_q;

`ifndef SYNTHESIS
	a_index_in_budget: assert property (@(posedge clk) disable iff (!arst_n)
		entry_index_q <= entry_total_q)
		else $error("entry index past entry total");

	a_emit_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (entry_index_q < entry_total_q))
		else $error("emitting with no entry left");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_idx_q < 4'(SLOTS))
		else $error("slot index out of range");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !last_d) |=> (state_q == S_EMIT))
		else $error("run ended before its last entry");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> in_stall)
		else $error("input taken while emitting");
`endif

endmodule
